/* rtl/core/scgi_pkg.sv */
// ----------------------------------------------------------------------------
// scgi_pkg
// Shared types, status codes and character helpers for the SCGI request framer.
// ----------------------------------------------------------------------------
package scgi_pkg;

    // Request phase, one-hot
    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_COMMA  = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    // Radix of the number being parsed
    typedef enum logic [1:0] {
        RAD_NONE = 2'd0,
        RAD_DEC  = 2'd1,
        RAD_OCT  = 2'd2,
        RAD_HEX  = 2'd3
    } t_radix;

    // Progress through the body-length value, one-hot
    typedef enum logic [3:0] {
        VP_START  = 4'b0001,
        VP_ZERO   = 4'b0010,
        VP_DIGITS = 4'b0100,
        VP_DONE   = 4'b1000
    } t_vphase;

    localparam logic [2:0] ST_BUSY   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_BADPFX = 3'd2;
    localparam logic [2:0] ST_SHORT  = 3'd3;
    localparam logic [2:0] ST_NAME   = 3'd4;
    localparam logic [2:0] ST_COMMA  = 3'd5;
    localparam logic [2:0] ST_LONG   = 3'd6;
    localparam logic [2:0] ST_TRUNC  = 3'd7;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HDR  = 2'd1;
    localparam logic [1:0] KIND_BODY = 2'd2;

    localparam logic [3:0]  NAME_LEN   = 4'd14;
    localparam int unsigned MIN_HEADER = 17;
    localparam int unsigned REQ_W      = 20;
    localparam logic [19:0] MAX_LEN_RESET = 20'd65536;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Expected first header name, one character per index
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            4'd0:    c = "C";
            4'd1:    c = "O";
            4'd2:    c = "N";
            4'd3:    c = "T";
            4'd4:    c = "E";
            4'd5:    c = "N";
            4'd6:    c = "T";
            4'd7:    c = "_";
            4'd8:    c = "L";
            4'd9:    c = "E";
            4'd10:   c = "N";
            4'd11:   c = "G";
            4'd12:   c = "T";
            4'd13:   c = "H";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit value, 16 for anything that is not a digit
    function automatic logic [4:0] digit_of(input logic [7:0] b);
        logic [4:0] d;
        d = 5'd16;
        if (b >= "0" && b <= "9") d = 5'(b - "0");
        else if (b >= "a" && b <= "f") d = 5'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") d = 5'(b - "A" + 8'd10);
        return d;
    endfunction

    function automatic logic [4:0] base_of(input t_radix r);
        logic [4:0] base;
        unique case (r)
            RAD_DEC: base = 5'd10;
            RAD_OCT: base = 5'd8;
            default: base = 5'd16;
        endcase
        return base;
    endfunction

    function automatic logic is_space_or_sign(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR) ||
               (b == CH_PLUS) || (b == CH_MINUS);
    endfunction

endpackage

/* rtl/core/scgi_request_framer.sv */
// ----------------------------------------------------------------------------
// scgi_request_framer
// Frames SCGI requests from a byte stream, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one beat per stream byte or
// a close event (i_action = 1). Output channel (o_out_valid / i_out_stall)
// returns exactly one result beat per input beat: status, byte kind, the
// passed byte and, on completion, the total request length.
// A result is registered, shown in the cycle after its beat is accepted.
// Throughput is one beat per cycle while the receiver does not stall; the
// parse state and result register both update in the accepting cycle, so
// back-to-back bytes flow without gaps. o_in_stall is high only while a
// result is held and the receiver stalls; the held result does not change.
// i_cfg_we / i_cfg_data write max_request_len; write it only while idle.
// Synchronous reset (i_rst_n low) returns the parser to idle, drops any
// pending result and sets max_request_len to 65536.
// Any error or a completed request returns the parser to idle.
// ----------------------------------------------------------------------------
module scgi_request_framer #(
    parameter int PREFIX_WINDOW = 12,
    parameter int LEN_BITS      = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_byte_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_out_byte,
    output logic [19:0] o_request_length
);

    localparam int PC_W  = $clog2(PREFIX_WINDOW);
    localparam int CMP_W = (LEN_BITS + 2 > 21) ? LEN_BITS + 2 : 21;

    // parse state
    scgi_pkg::t_phase   r_phase,  n_phase;
    logic [PC_W-1:0]    r_pc,     n_pc;
    scgi_pkg::t_radix   r_radix,  n_radix;
    logic [LEN_BITS-1:0] r_hlen,  n_hlen;
    logic [LEN_BITS-1:0] r_hleft, n_hleft;
    logic [3:0]         r_ni,     n_ni;
    scgi_pkg::t_vphase  r_vp,     n_vp;
    logic [LEN_BITS-1:0] r_blen,  n_blen;
    logic [LEN_BITS-1:0] r_bleft, n_bleft;
    logic [19:0]        r_total,  n_total;
    logic [19:0]        r_max_len;

    // result register
    logic               r_out_valid;
    logic [2:0]         r_status, n_status;
    logic [1:0]         r_kind,   n_kind;
    logic [7:0]         r_byte,   n_byte;
    logic [19:0]        r_len,    n_len;

    logic               accept;
    logic [4:0]         digit;
    logic [4:0]         base;
    logic [LEN_BITS-1:0] acc_in;
    logic [LEN_BITS-1:0] acc_out;
    logic [CMP_W-1:0]   head_total;
    logic [CMP_W-1:0]   req_total;
    logic [CMP_W-1:0]   max_ext;
    logic [PC_W:0]      pc_next;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign digit   = scgi_pkg::digit_of(i_byte_req);
    assign base    = scgi_pkg::base_of(r_radix);
    assign acc_in  = (r_phase == scgi_pkg::PH_PREFIX) ? r_hlen : r_blen;
    assign pc_next = (PC_W+1)'(r_pc) + (PC_W+1)'(1);

    assign head_total = CMP_W'(r_pc) + CMP_W'(2) + CMP_W'(r_hlen);
    assign req_total  = head_total + CMP_W'(r_blen);
    assign max_ext    = CMP_W'(r_max_len);

    scgi_accum #(
        .LEN_BITS (LEN_BITS)
    ) u_accum (
        .i_acc   (acc_in),
        .i_radix (r_radix),
        .i_digit (digit[3:0]),
        .o_acc   (acc_out)
    );

    always_comb begin
        n_phase  = r_phase;
        n_pc     = r_pc;
        n_radix  = r_radix;
        n_hlen   = r_hlen;
        n_hleft  = r_hleft;
        n_ni     = r_ni;
        n_vp     = r_vp;
        n_blen   = r_blen;
        n_bleft  = r_bleft;
        n_total  = r_total;
        n_status = scgi_pkg::ST_BUSY;
        n_kind   = scgi_pkg::KIND_HDR;
        n_len    = '0;

        if (i_action) begin
            // close: quiet only when nothing of a request has been seen
            n_status = (r_phase == scgi_pkg::PH_PREFIX && r_pc == '0 &&
                        r_radix == scgi_pkg::RAD_NONE) ?
                       scgi_pkg::ST_BUSY : scgi_pkg::ST_TRUNC;
            n_kind   = scgi_pkg::KIND_NONE;
        end else begin
            unique case (r_phase)
                scgi_pkg::PH_PREFIX: begin
                    if (i_byte_req == scgi_pkg::CH_COLON) begin
                        if (r_pc == '0)
                            n_status = scgi_pkg::ST_SHORT;
                        else if (r_radix == scgi_pkg::RAD_HEX && r_pc == PC_W'(2))
                            n_status = scgi_pkg::ST_BADPFX;
                        else if (r_hlen < LEN_BITS'(scgi_pkg::MIN_HEADER))
                            n_status = scgi_pkg::ST_SHORT;
                        else if (head_total > max_ext)
                            n_status = scgi_pkg::ST_LONG;
                        else begin
                            n_phase = scgi_pkg::PH_HEADER;
                            n_hleft = r_hlen;
                            n_radix = scgi_pkg::RAD_NONE;
                        end
                    end else if (pc_next >= (PC_W+1)'(PREFIX_WINDOW)) begin
                        n_status = scgi_pkg::ST_BADPFX;
                    end else begin
                        if (r_radix == scgi_pkg::RAD_NONE) begin
                            if (i_byte_req == scgi_pkg::CH_ZERO)
                                n_radix = scgi_pkg::RAD_OCT;
                            else if (i_byte_req >= scgi_pkg::CH_ONE &&
                                     i_byte_req <= scgi_pkg::CH_NINE) begin
                                n_radix = scgi_pkg::RAD_DEC;
                                n_hlen  = LEN_BITS'(digit);
                            end else
                                n_status = scgi_pkg::ST_BADPFX;
                        end else if (r_radix == scgi_pkg::RAD_OCT && r_pc == PC_W'(1) &&
                                     (i_byte_req == scgi_pkg::CH_X_LO ||
                                      i_byte_req == scgi_pkg::CH_X_UP)) begin
                            n_radix = scgi_pkg::RAD_HEX;
                        end else if (digit >= base) begin
                            n_status = scgi_pkg::ST_BADPFX;
                        end else begin
                            n_hlen = acc_out;
                        end
                        if (n_status == scgi_pkg::ST_BUSY)
                            n_pc = pc_next[PC_W-1:0];
                    end
                end
                scgi_pkg::PH_HEADER: begin
                    if (r_ni < scgi_pkg::NAME_LEN) begin
                        if (i_byte_req != scgi_pkg::name_char(r_ni))
                            n_status = scgi_pkg::ST_NAME;
                        else
                            n_ni = r_ni + 4'd1;
                    end else if (r_ni == scgi_pkg::NAME_LEN) begin
                        if (i_byte_req != scgi_pkg::CH_NUL)
                            n_status = scgi_pkg::ST_NAME;
                        else
                            n_ni = r_ni + 4'd1;
                    end else begin
                        unique case (r_vp)
                            scgi_pkg::VP_START: begin
                                if (i_byte_req == scgi_pkg::CH_ZERO) begin
                                    n_radix = scgi_pkg::RAD_OCT;
                                    n_vp    = scgi_pkg::VP_ZERO;
                                end else if (i_byte_req >= scgi_pkg::CH_ONE &&
                                             i_byte_req <= scgi_pkg::CH_NINE) begin
                                    n_radix = scgi_pkg::RAD_DEC;
                                    n_blen  = LEN_BITS'(digit);
                                    n_vp    = scgi_pkg::VP_DIGITS;
                                end else if (scgi_pkg::is_space_or_sign(i_byte_req))
                                    n_status = scgi_pkg::ST_NAME;
                                else
                                    n_vp = scgi_pkg::VP_DONE;
                            end
                            scgi_pkg::VP_ZERO: begin
                                if (i_byte_req == scgi_pkg::CH_X_LO ||
                                    i_byte_req == scgi_pkg::CH_X_UP) begin
                                    n_radix = scgi_pkg::RAD_HEX;
                                    n_vp    = scgi_pkg::VP_DIGITS;
                                end else if (digit < 5'd8) begin
                                    n_blen = LEN_BITS'(digit);
                                    n_vp   = scgi_pkg::VP_DIGITS;
                                end else
                                    n_vp = scgi_pkg::VP_DONE;
                            end
                            scgi_pkg::VP_DIGITS: begin
                                if (digit < base)
                                    n_blen = acc_out;
                                else
                                    n_vp = scgi_pkg::VP_DONE;
                            end
                            default: ;
                        endcase
                    end
                    if (n_status == scgi_pkg::ST_BUSY) begin
                        n_hleft = r_hleft - LEN_BITS'(1);
                        if (r_hleft == LEN_BITS'(1))
                            n_phase = scgi_pkg::PH_COMMA;
                    end
                end
                scgi_pkg::PH_COMMA: begin
                    if (i_byte_req != scgi_pkg::CH_COMMA)
                        n_status = scgi_pkg::ST_COMMA;
                    else if (req_total > max_ext)
                        n_status = scgi_pkg::ST_LONG;
                    else if (r_blen == '0) begin
                        n_status = scgi_pkg::ST_DONE;
                        n_len    = req_total[19:0];
                    end else begin
                        n_phase = scgi_pkg::PH_BODY;
                        n_bleft = r_blen;
                        // hold the total for the last body beat
                        n_total = req_total[19:0];
                    end
                end
                scgi_pkg::PH_BODY: begin
                    n_kind  = scgi_pkg::KIND_BODY;
                    n_bleft = r_bleft - LEN_BITS'(1);
                    if (r_bleft == LEN_BITS'(1)) begin
                        n_status = scgi_pkg::ST_DONE;
                        n_len    = r_total;
                    end
                end
                default: ;
            endcase
        end

        // errors drop the byte
        if (n_status != scgi_pkg::ST_BUSY && n_status != scgi_pkg::ST_DONE)
            n_kind = scgi_pkg::KIND_NONE;

        // any final status returns to idle
        if (n_status != scgi_pkg::ST_BUSY || i_action) begin
            n_phase = scgi_pkg::PH_PREFIX;
            n_pc    = '0;
            n_radix = scgi_pkg::RAD_NONE;
            n_hlen  = '0;
            n_hleft = '0;
            n_ni    = '0;
            n_vp    = scgi_pkg::VP_START;
            n_blen  = '0;
            n_bleft = '0;
        end

        n_byte = (n_kind != scgi_pkg::KIND_NONE) ? i_byte_req : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= scgi_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= scgi_pkg::PH_PREFIX;
            r_pc    <= '0;
            r_radix <= scgi_pkg::RAD_NONE;
            r_hlen  <= '0;
            r_hleft <= '0;
            r_ni    <= '0;
            r_vp    <= scgi_pkg::VP_START;
            r_blen  <= '0;
            r_bleft <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pc    <= n_pc;
            r_radix <= n_radix;
            r_hlen  <= n_hlen;
            r_hleft <= n_hleft;
            r_ni    <= n_ni;
            r_vp    <= n_vp;
            r_blen  <= n_blen;
            r_bleft <= n_bleft;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_total  <= n_total;
            r_status <= n_status;
            r_kind   <= n_kind;
            r_byte   <= n_byte;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_byte_kind      = r_kind;
    assign o_out_byte       = r_byte;
    assign o_request_length = r_len;

endmodule

/* rtl/core/scgi_accum.sv */
// ----------------------------------------------------------------------------
// scgi_accum
// Saturating digit accumulator: acc * base + digit for base 8, 10 or 16.
// ----------------------------------------------------------------------------
module scgi_accum #(
    parameter int LEN_BITS = 21
) (
    input  logic [LEN_BITS-1:0] i_acc,
    input  scgi_pkg::t_radix    i_radix,
    input  logic [3:0]          i_digit,
    output logic [LEN_BITS-1:0] o_acc
);

    localparam int WIDE_W = LEN_BITS + 5;

    logic [WIDE_W-1:0] wide;
    logic [WIDE_W-1:0] prod;
    logic [WIDE_W-1:0] sum;

    assign wide = WIDE_W'(i_acc);

    always_comb begin
        unique case (i_radix)
            scgi_pkg::RAD_DEC: prod = (wide << 3) + (wide << 1);
            scgi_pkg::RAD_OCT: prod = wide << 3;
            default:           prod = wide << 4;
        endcase
    end

    assign sum   = prod + WIDE_W'(i_digit);
    // clamp at all ones once the value leaves the length width
    assign o_acc = (|sum[WIDE_W-1:LEN_BITS]) ? {LEN_BITS{1'b1}} : sum[LEN_BITS-1:0];

endmodule

/* rtl/core/scgi_checker.sv */
// ----------------------------------------------------------------------------
// scgi_checker
// Port-level checks for the SCGI request framer, bound to the top level.
// ----------------------------------------------------------------------------
module scgi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [1:0]  o_byte_kind,
    input logic [7:0]  o_out_byte,
    input logic [19:0] o_request_length
);

    // a held result stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // every accepted beat produces a result beat next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted beat produced no result");

    a_len_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != scgi_pkg::ST_DONE |-> o_request_length == 20'd0)
        else $error("length reported without completion");

    a_error_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != scgi_pkg::ST_BUSY && o_status != scgi_pkg::ST_DONE
        |-> o_byte_kind == scgi_pkg::KIND_NONE)
        else $error("byte passed on an error");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_kind == scgi_pkg::KIND_NONE |-> o_out_byte == 8'h00)
        else $error("out byte nonzero with no byte passed");

endmodule

bind scgi_request_framer scgi_checker u_scgi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_byte_kind      (o_byte_kind),
    .o_out_byte       (o_out_byte),
    .o_request_length (o_request_length)
);

/* test/scgi_request_framer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scgi_request_framer_tb
// Streams SCGI requests, well-formed and broken, into the framer and checks
// every result beat against a cycle-free model of the parser. The run steps
// through several max_request_len settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module scgi_request_framer_tb;

    localparam int LEN_W       = 21;
    localparam int WINDOW      = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_CAP  = 30;
    localparam int PHASE_ITEMS = 100;
    localparam logic [LEN_W-1:0] LEN_SAT = '1;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum int {VAL_PLAIN, VAL_BARE_HEX, VAL_EMPTY, VAL_SIGNED, VAL_HUGE} t_value_style;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [19:0] length;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [19:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_action    = 1'b0;
    logic [7:0]  i_byte_req  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [1:0]  o_byte_kind;
    logic [7:0]  o_out_byte;
    logic [19:0] o_request_length;

    scgi_request_framer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_byte_req       (i_byte_req),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_byte_kind      (o_byte_kind),
        .o_out_byte       (o_out_byte),
        .o_request_length (o_request_length)
    );

    // Parser state mirrored from the framer
    scgi_pkg::t_phase  fr_phase;
    logic [3:0]        fr_prefix_cnt;
    scgi_pkg::t_radix  fr_radix;
    logic [LEN_W-1:0]  fr_hdr_len;
    logic [LEN_W-1:0]  fr_hdr_left;
    logic [3:0]        fr_name_idx;
    scgi_pkg::t_vphase fr_vphase;
    logic [LEN_W-1:0]  fr_body_len;
    logic [LEN_W-1:0]  fr_body_left;
    logic [19:0]       fr_max_len;

    t_beat         stream_beats[$];
    t_frame_result parsed_beats[$];
    logic [7:0]    num_text[$];
    logic [7:0]    hdr_bytes[$];
    logic [7:0]    req_bytes[$];

    logic send_gaps  = 1'b0;
    logic rcv_stalls = 1'b0;
    int   gap_pct    = 0;
    int   stall_pct  = 0;

    int cycle_count  = 0;
    int fail_count   = 0;
    int queued_total = 0;
    int beats_taken  = 0;
    int settings_run = 1;
    int status_seen[8];
    t_frame_result want;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
        return 5'd16;
    endfunction

    function automatic logic [4:0] radix_base(input scgi_pkg::t_radix r);
        if (r == scgi_pkg::RAD_DEC) return 5'd10;
        if (r == scgi_pkg::RAD_OCT) return 5'd8;
        return 5'd16;
    endfunction

    function automatic logic [LEN_W-1:0] scale_add(input logic [LEN_W-1:0] acc,
                                                   input scgi_pkg::t_radix r,
                                                   input logic [4:0] d);
        logic [31:0] v;
        v = 32'(acc) * 32'(radix_base(r)) + 32'(d);
        return (v > 32'(LEN_SAT)) ? LEN_SAT : v[LEN_W-1:0];
    endfunction

    function automatic logic [7:0] name_at(input int idx);
        return scgi_pkg::name_char(4'(idx));
    endfunction

    function automatic logic blank_or_sign(input logic [7:0] b);
        return (b == scgi_pkg::CH_SPACE) ||
               (b >= scgi_pkg::CH_TAB && b <= scgi_pkg::CH_CR) ||
               (b == scgi_pkg::CH_PLUS) || (b == scgi_pkg::CH_MINUS);
    endfunction

    function automatic logic [31:0] head_bytes();
        return 32'(fr_prefix_cnt) + 32'd2 + 32'(fr_hdr_len);
    endfunction

    function automatic void clear_frame();
        fr_phase      = scgi_pkg::PH_PREFIX;
        fr_prefix_cnt = '0;
        fr_radix      = scgi_pkg::RAD_NONE;
        fr_hdr_len    = '0;
        fr_hdr_left   = '0;
        fr_name_idx   = '0;
        fr_vphase     = scgi_pkg::VP_START;
        fr_body_len   = '0;
        fr_body_left  = '0;
    endfunction

    function automatic logic [2:0] prefix_step(input logic [7:0] b);
        logic [4:0] d;
        d = hex_value(b);
        if (b == scgi_pkg::CH_COLON) begin
            if (fr_prefix_cnt == 0) return scgi_pkg::ST_SHORT;
            if (fr_radix == scgi_pkg::RAD_HEX && fr_prefix_cnt == 2)
                return scgi_pkg::ST_BADPFX;
            if (fr_hdr_len < scgi_pkg::MIN_HEADER) return scgi_pkg::ST_SHORT;
            if (head_bytes() > 32'(fr_max_len)) return scgi_pkg::ST_LONG;
            fr_phase    = scgi_pkg::PH_HEADER;
            fr_hdr_left = fr_hdr_len;
            fr_radix    = scgi_pkg::RAD_NONE;
            return scgi_pkg::ST_BUSY;
        end
        if (32'(fr_prefix_cnt) + 1 >= WINDOW) return scgi_pkg::ST_BADPFX;
        if (fr_radix == scgi_pkg::RAD_NONE) begin
            if (b == scgi_pkg::CH_ZERO) begin
                fr_radix = scgi_pkg::RAD_OCT;
            end else if (b >= scgi_pkg::CH_ONE && b <= scgi_pkg::CH_NINE) begin
                fr_radix   = scgi_pkg::RAD_DEC;
                fr_hdr_len = LEN_W'(d);
            end else begin
                return scgi_pkg::ST_BADPFX;
            end
        end else if (fr_radix == scgi_pkg::RAD_OCT && fr_prefix_cnt == 1 &&
                     (b == scgi_pkg::CH_X_LO || b == scgi_pkg::CH_X_UP)) begin
            fr_radix = scgi_pkg::RAD_HEX;
        end else begin
            if (d >= radix_base(fr_radix)) return scgi_pkg::ST_BADPFX;
            fr_hdr_len = scale_add(fr_hdr_len, fr_radix, d);
        end
        fr_prefix_cnt++;
        return scgi_pkg::ST_BUSY;
    endfunction

    function automatic logic [2:0] value_step(input logic [7:0] b);
        logic [4:0] d;
        d = hex_value(b);
        case (fr_vphase)
            scgi_pkg::VP_START: begin
                if (b == scgi_pkg::CH_ZERO) begin
                    fr_radix  = scgi_pkg::RAD_OCT;
                    fr_vphase = scgi_pkg::VP_ZERO;
                end else if (b >= scgi_pkg::CH_ONE && b <= scgi_pkg::CH_NINE) begin
                    fr_radix    = scgi_pkg::RAD_DEC;
                    fr_body_len = LEN_W'(d);
                    fr_vphase   = scgi_pkg::VP_DIGITS;
                end else if (blank_or_sign(b)) begin
                    return scgi_pkg::ST_NAME;
                end else begin
                    fr_vphase = scgi_pkg::VP_DONE;
                end
            end
            scgi_pkg::VP_ZERO: begin
                if (b == scgi_pkg::CH_X_LO || b == scgi_pkg::CH_X_UP) begin
                    fr_radix  = scgi_pkg::RAD_HEX;
                    fr_vphase = scgi_pkg::VP_DIGITS;
                end else if (d < 5'd8) begin
                    fr_body_len = LEN_W'(d);
                    fr_vphase   = scgi_pkg::VP_DIGITS;
                end else begin
                    fr_vphase = scgi_pkg::VP_DONE;
                end
            end
            scgi_pkg::VP_DIGITS: begin
                if (d < radix_base(fr_radix))
                    fr_body_len = scale_add(fr_body_len, fr_radix, d);
                else
                    fr_vphase = scgi_pkg::VP_DONE;
            end
            default: ;
        endcase
        return scgi_pkg::ST_BUSY;
    endfunction

    function automatic logic [2:0] header_step(input logic [7:0] b);
        logic [2:0] st;
        if (fr_name_idx < scgi_pkg::NAME_LEN) begin
            if (b != name_at(int'(fr_name_idx))) return scgi_pkg::ST_NAME;
            fr_name_idx++;
        end else if (fr_name_idx == scgi_pkg::NAME_LEN) begin
            if (b != scgi_pkg::CH_NUL) return scgi_pkg::ST_NAME;
            fr_name_idx++;
        end else begin
            st = value_step(b);
            if (st != scgi_pkg::ST_BUSY) return st;
        end
        fr_hdr_left--;
        if (fr_hdr_left == 0) fr_phase = scgi_pkg::PH_COMMA;
        return scgi_pkg::ST_BUSY;
    endfunction

    function automatic t_frame_result frame_beat(input logic act, input logic [7:0] b);
        t_frame_result r;
        logic [2:0]    st;
        logic [1:0]    kind;
        logic [31:0]   total;
        st    = scgi_pkg::ST_BUSY;
        kind  = scgi_pkg::KIND_HDR;
        total = '0;
        if (act) begin
            st = (fr_phase == scgi_pkg::PH_PREFIX && fr_prefix_cnt == 0 &&
                  fr_radix == scgi_pkg::RAD_NONE) ? scgi_pkg::ST_BUSY : scgi_pkg::ST_TRUNC;
            kind = scgi_pkg::KIND_NONE;
            clear_frame();
        end else begin
            case (fr_phase)
                scgi_pkg::PH_PREFIX: st = prefix_step(b);
                scgi_pkg::PH_HEADER: st = header_step(b);
                scgi_pkg::PH_COMMA: begin
                    if (b != scgi_pkg::CH_COMMA) begin
                        st = scgi_pkg::ST_COMMA;
                    end else begin
                        total = head_bytes() + 32'(fr_body_len);
                        if (total > 32'(fr_max_len)) begin
                            st = scgi_pkg::ST_LONG;
                        end else if (fr_body_len == 0) begin
                            st = scgi_pkg::ST_DONE;
                        end else begin
                            fr_phase     = scgi_pkg::PH_BODY;
                            fr_body_left = fr_body_len;
                            total        = '0;
                        end
                    end
                end
                default: begin
                    kind = scgi_pkg::KIND_BODY;
                    fr_body_left--;
                    if (fr_body_left == 0) begin
                        st    = scgi_pkg::ST_DONE;
                        total = head_bytes() + 32'(fr_body_len);
                    end
                end
            endcase
        end
        if (st != scgi_pkg::ST_BUSY && st != scgi_pkg::ST_DONE) kind = scgi_pkg::KIND_NONE;
        if (st != scgi_pkg::ST_DONE) total = '0;
        if (st != scgi_pkg::ST_BUSY) clear_frame();
        r.status = st;
        r.kind   = kind;
        r.data   = (kind != scgi_pkg::KIND_NONE) ? b : 8'h00;
        r.length = total[19:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one beat from the pending queue, held while stalled
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat nb;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_action   <= 1'b0;
            i_byte_req <= 8'h00;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                parsed_beats.insert(parsed_beats.size(), frame_beat(i_action, i_byte_req));
                beats_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (stream_beats.size() != 0 &&
                    !(send_gaps && $urandom_range(0, 99) < gap_pct)) begin
                    nb = stream_beats[0];
                    stream_beats.delete(0);
                    i_in_valid <= 1'b1;
                    i_action   <= nb.act;
                    i_byte_req <= nb.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (parsed_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t unexpected beat, expected none: got status %0d %s",
                                 $time, o_status, "");
                    if (fail_count <= REPORT_CAP)
                        $display("%0t   kind %0d byte %02h length %0d",
                                 $time, o_byte_kind, o_out_byte, o_request_length);
                end else begin
                    want = parsed_beats[0];
                    parsed_beats.delete(0);
                    if (o_status !== want.status || o_byte_kind !== want.kind ||
                        o_out_byte !== want.data || o_request_length !== want.length) begin
                        fail_count++;
                        if (fail_count <= REPORT_CAP) begin
                            $display("%0t mismatch: expected status %0d kind %0d byte %02h length %0d",
                                     $time, want.status, want.kind, want.data, want.length);
                            $display("%0t           actual status %0d kind %0d byte %02h length %0d",
                                     $time, o_status, o_byte_kind, o_out_byte, o_request_length);
                        end
                    end
                end
                if (!$isunknown(o_status)) status_seen[o_status]++;
            end
            i_out_stall <= rcv_stalls && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic act, input logic [7:0] b);
        t_beat nb;
        nb.act  = act;
        nb.data = b;
        stream_beats.insert(stream_beats.size(), nb);
        queued_total++;
    endtask

    task automatic push_request_bytes(input int count);
        for (int i = 0; i < count; i++) push_beat(1'b0, req_bytes[i]);
    endtask

    function automatic logic [7:0] hex_char(input int unsigned nib, input logic upper);
        if (nib < 10) return 8'(scgi_pkg::CH_ZERO + nib);
        return 8'((upper ? "A" : "a") + nib - 10);
    endfunction

    // Spell a number into num_text in the given radix, with C-style prefixes
    task automatic spell_number(input int unsigned v, input scgi_pkg::t_radix r);
        int unsigned rest;
        logic [7:0]  digs[$];
        logic        upper;
        num_text.delete();
        rest  = v;
        upper = 1'($urandom);
        if (r == scgi_pkg::RAD_DEC) begin
            if (v == 0) digs.insert(digs.size(), scgi_pkg::CH_ZERO);
            while (rest > 0) begin
                digs.push_front(8'(scgi_pkg::CH_ZERO + rest % 10));
                rest = rest / 10;
            end
        end else begin
            num_text.insert(num_text.size(), scgi_pkg::CH_ZERO);
            if (r == scgi_pkg::RAD_HEX) begin
                num_text.insert(num_text.size(),
                                upper ? scgi_pkg::CH_X_UP : scgi_pkg::CH_X_LO);
                if (v == 0) digs.insert(digs.size(), scgi_pkg::CH_ZERO);
            end
            while (rest > 0) begin
                if (r == scgi_pkg::RAD_HEX) begin
                    digs.push_front(hex_char(rest % 16, 1'($urandom)));
                    rest = rest / 16;
                end else begin
                    digs.push_front(8'(scgi_pkg::CH_ZERO + rest % 8));
                    rest = rest / 8;
                end
            end
            if ($urandom_range(0, 3) == 0) digs.push_front(scgi_pkg::CH_ZERO);
        end
        foreach (digs[i]) num_text.insert(num_text.size(), digs[i]);
    endtask

    // Build one complete request into req_bytes
    task automatic compose_request(input t_value_style style);
        int pay_len;
        int nfill;
        int ndig;
        pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
        hdr_bytes.delete();
        for (int i = 0; i < scgi_pkg::NAME_LEN; i++)
            hdr_bytes.insert(hdr_bytes.size(), name_at(i));
        hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_NUL);
        case (style)
            VAL_PLAIN: begin
                spell_number(pay_len, scgi_pkg::t_radix'($urandom_range(1, 3)));
                foreach (num_text[i]) hdr_bytes.insert(hdr_bytes.size(), num_text[i]);
            end
            VAL_BARE_HEX: begin
                hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_ZERO);
                hdr_bytes.insert(hdr_bytes.size(),
                                 $urandom_range(0, 1) ? scgi_pkg::CH_X_UP : scgi_pkg::CH_X_LO);
            end
            VAL_SIGNED: begin
                case ($urandom_range(0, 4))
                    0: hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_SPACE);
                    1: hdr_bytes.insert(hdr_bytes.size(),
                                        8'($urandom_range(scgi_pkg::CH_TAB, scgi_pkg::CH_CR)));
                    2: hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_PLUS);
                    3: hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_MINUS);
                    default: hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_TAB);
                endcase
                spell_number(pay_len, scgi_pkg::RAD_DEC);
                foreach (num_text[i]) hdr_bytes.insert(hdr_bytes.size(), num_text[i]);
            end
            VAL_HUGE: begin
                hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_ZERO);
                hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_X_LO);
                ndig = $urandom_range(5, 8);
                hdr_bytes.insert(hdr_bytes.size(), hex_char($urandom_range(1, 15), 1'($urandom)));
                for (int i = 1; i < ndig; i++)
                    hdr_bytes.insert(hdr_bytes.size(),
                                     hex_char($urandom_range(0, 15), 1'($urandom)));
            end
            default: ;
        endcase
        // only a plain value carries a body that gets sent
        if (style != VAL_PLAIN) pay_len = 0;
        hdr_bytes.insert(hdr_bytes.size(), scgi_pkg::CH_NUL);
        nfill = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
        while (hdr_bytes.size() < scgi_pkg::MIN_HEADER || nfill > 0) begin
            hdr_bytes.insert(hdr_bytes.size(), 8'($urandom));
            if (nfill > 0) nfill--;
        end
        req_bytes.delete();
        spell_number(hdr_bytes.size(), scgi_pkg::t_radix'($urandom_range(1, 3)));
        foreach (num_text[i]) req_bytes.insert(req_bytes.size(), num_text[i]);
        req_bytes.insert(req_bytes.size(), scgi_pkg::CH_COLON);
        foreach (hdr_bytes[i]) req_bytes.insert(req_bytes.size(), hdr_bytes[i]);
        req_bytes.insert(req_bytes.size(), scgi_pkg::CH_COMMA);
        for (int i = 0; i < pay_len; i++) req_bytes.insert(req_bytes.size(), 8'($urandom));
    endtask

    task automatic queue_random_traffic(input int target);
        int start;
        int roll;
        int n;
        int pos;
        int signed near;
        start = queued_total;
        while (queued_total - start < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 63) begin
                compose_request(roll < 55 ? VAL_PLAIN : t_value_style'($urandom_range(1, 4)));
                push_request_bytes(req_bytes.size());
            end else if (roll < 71) begin
                // one damaged byte anywhere in the request
                compose_request(VAL_PLAIN);
                pos = $urandom_range(0, req_bytes.size() - 1);
                req_bytes[pos] = 8'($urandom);
                push_request_bytes(req_bytes.size());
            end else if (roll < 77) begin
                // connection drops partway through
                compose_request(VAL_PLAIN);
                push_request_bytes($urandom_range(0, req_bytes.size() - 1));
                push_beat(1'b1, 8'($urandom));
            end else if (roll < 83) begin
                // length prefix near or past the size limit
                if ($urandom_range(0, 1)) begin
                    spell_number($urandom, scgi_pkg::t_radix'($urandom_range(1, 3)));
                end else begin
                    near = int'(fr_max_len) + $urandom_range(0, 16) - 14;
                    spell_number((near < 0) ? 0 : near, scgi_pkg::RAD_DEC);
                end
                foreach (num_text[i]) push_beat(1'b0, num_text[i]);
                push_beat(1'b0, scgi_pkg::CH_COLON);
            end else if (roll < 88) begin
                // digits that fill or run past the prefix window
                n = $urandom_range(11, 13);
                push_beat(1'b0, 8'($urandom_range(scgi_pkg::CH_ONE, scgi_pkg::CH_NINE)));
                for (int i = 1; i < n; i++)
                    push_beat(1'b0, 8'($urandom_range(scgi_pkg::CH_ZERO, scgi_pkg::CH_NINE)));
                if ($urandom_range(0, 1)) push_beat(1'b0, scgi_pkg::CH_COLON);
            end else if (roll < 94) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) push_beat(1'b0, 8'($urandom));
            end else begin
                push_beat(1'b1, 8'($urandom));
            end
        end
        // leave the parser idle for the next register write
        push_beat(1'b1, 8'($urandom));
    endtask

    task automatic set_idling(input t_idle_mode m);
        send_gaps  = (m == IDLE_SEND) || (m == IDLE_BOTH);
        rcv_stalls = (m == IDLE_RECV) || (m == IDLE_BOTH);
        gap_pct    = (m == IDLE_BOTH) ? 26 : 46;
        stall_pct  = (m == IDLE_BOTH) ? 26 : 46;
    endtask

    task automatic drain();
        while (stream_beats.size() != 0 || i_in_valid || parsed_beats.size() != 0)
            @(negedge i_clk);
        // let any stray result beats drain as well
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_max_len(input logic [19:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        fr_max_len  = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        settings_run++;
    endtask

    task automatic run_phase(input logic [19:0] lim, input t_idle_mode m, input int n);
        write_max_len(lim);
        set_idling(m);
        queue_random_traffic(n);
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_frame();
        fr_max_len = scgi_pkg::MAX_LEN_RESET;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: prefix corner cases at the reset limit
        set_idling(IDLE_NONE);
        push_beat(1'b1, 8'h00);                 // close with nothing received
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hff);
        push_beat(1'b0, scgi_pkg::CH_SPACE);
        push_beat(1'b0, scgi_pkg::CH_MINUS);
        push_beat(1'b0, scgi_pkg::CH_PLUS);
        push_beat(1'b0, scgi_pkg::CH_COLON);    // empty length
        push_beat(1'b0, "1");
        push_beat(1'b0, "6");
        push_beat(1'b0, scgi_pkg::CH_COLON);    // below the minimum header
        push_beat(1'b0, scgi_pkg::CH_ZERO);
        push_beat(1'b0, scgi_pkg::CH_X_UP);
        push_beat(1'b0, scgi_pkg::CH_COLON);    // hex marker without digits
        push_beat(1'b0, scgi_pkg::CH_ZERO);
        push_beat(1'b0, "8");                   // not an octal digit
        push_beat(1'b0, "7");
        push_beat(1'b0, "a");                   // not a decimal digit
        push_beat(1'b0, "a");
        push_beat(1'b0, scgi_pkg::CH_ZERO);
        push_beat(1'b1, 8'hff);                 // close mid-prefix
        drain();

        run_phase(20'd1048575, IDLE_NONE, PHASE_ITEMS);
        run_phase(20'd32,      IDLE_SEND, PHASE_ITEMS);
        run_phase(20'd48,      IDLE_RECV, PHASE_ITEMS);
        run_phase(20'($urandom_range(32, 1048575)), IDLE_BOTH, PHASE_ITEMS);
        run_phase(20'd1048575, IDLE_SEND, PHASE_ITEMS);
        run_phase(20'd100,     IDLE_RECV, PHASE_ITEMS);
        run_phase(20'd65536,   IDLE_BOTH, PHASE_ITEMS);

        $display("framed %0d beats under %0d max_request_len settings and four idle mixes",
                 beats_taken, settings_run);
        $display("results: %0d complete, %0d truncated, %0d other errors",
                 status_seen[scgi_pkg::ST_DONE], status_seen[scgi_pkg::ST_TRUNC],
                 status_seen[scgi_pkg::ST_BADPFX] + status_seen[scgi_pkg::ST_SHORT] +
                 status_seen[scgi_pkg::ST_NAME] + status_seen[scgi_pkg::ST_COMMA] +
                 status_seen[scgi_pkg::ST_LONG]);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
